// ===== design/iqr_pkg.sv =====
package iqr_pkg;

   // fixed field widths of the result word
   localparam int MEAN_W   = 32;
   localparam int HALF_W   = 33;
   localparam int OCOUNT_W = 11;
   localparam int RSP_W    = 160;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } iqr_div_stat_type;

endpackage

// ===== design/iqr_ram.sv =====
module iqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/iqr_divider.sv =====
module iqr_divider import iqr_pkg::*; #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output iqr_div_stat_type stat
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [DEN_W:0]    rem_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DEN_W+1:0]  shifted;
   logic [DEN_W+1:0]  diff;

   // one restoring step per cycle
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - (DEN_W+2)'(divisor);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            step_ff <= STEP_W'(NUM_W);
         end else if (busy_ff) begin
            if (!diff[DEN_W+1]) begin
               rem_ff <= diff[DEN_W:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[DEN_W:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== design/iqr_outlier_statistics_core.sv =====
// Tukey outlier statistics over a set of samples.
// req_ channel: one sample per word in tdata, tlast closes the set. Samples
// load one per cycle into the sample RAM; samples beyond MAX_SAMPLES are
// dropped and flagged in the result.
// rsp_ channel: one result word per set: truncated mean, median and both
// quartiles in half units, count of samples above Q3 + 1.5*IQR, sample
// count; tuser carries the overflow flag.
// After the closing word the block stops taking words and works on the set:
// insertion sort in the RAM, one compare a cycle; six reads for the medians;
// a scan of the stored samples to count outliers; a bit-serial divide for
// the mean; then a load of the output register. The RAM's single read port
// sets the sort and count times.
// A finished result sits in the output register while the next set loads;
// if the receiver stalls past the end of that set, the block waits there.
// Reset empties the set and drops any pending result; RAM contents are not
// cleared, only entries written in the current set are read.
module iqr_outlier_statistics_core import iqr_pkg::*; #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // sample
   input  logic             req_tlast,   // last
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // mean_value, median_half, lower_quartile_half, upper_quartile_half,
   // outlier_count, sample_count, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tuser    // overflowed
);

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int SB    = SAMPLE_BITS;
   localparam int HW    = SB + 1;
   localparam int BW    = SB + 4;
   localparam int SUM_W = SB + CW;

   typedef enum logic [3:0] {
      S_LOAD, S_FETCH, S_VALUE, S_CMP, S_PLACE,
      S_QUART, S_BOUND, S_SCAN, S_DIV, S_DONE
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     cnt_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              drop_ff;
   logic [CW-1:0]     i_ff;
   logic [CW-1:0]     j_ff;
   logic [SB-1:0]     v_ff;
   logic [2:0]        k_ff;
   logic [HW-1:0]     med_ff;
   logic [HW-1:0]     q1_ff;
   logic [HW-1:0]     q3_ff;
   logic [BW-1:0]     bound_ff;
   logic [CW-1:0]     idx_ff;
   logic              pend_ff;
   logic [CW-1:0]     outl_ff;
   logic              div_start_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              rsp_user_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [SB-1:0]     wr_data;
   logic [AW-1:0]     rd_addr;
   logic [SB-1:0]     rd_data;
   logic [SB-1:0]     sample;
   logic              req_acc;
   logic              has_room;
   logic              rsp_load;
   logic [CW-1:0]     n_after;
   logic [CW-1:0]     half_n;
   logic [CW-1:0]     hq;
   logic [CW-1:0]     quart_addr;
   logic              shift_gt;
   logic [SUM_W-1:0]  quotient;
   iqr_div_stat_type  div_stat;
   logic [127:0]      mean_wide;
   logic [63:0]       med_wide;
   logic [63:0]       q1_wide;
   logic [63:0]       q3_wide;
   logic [63:0]       outl_wide;
   logic [63:0]       cnt_wide;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign sample     = SB'(req_tdata);
   assign has_room   = (cnt_ff < CW'(MAX_SAMPLES));
   assign n_after    = has_room ? cnt_ff + 1'b1 : cnt_ff;
   assign shift_gt   = (rd_data > v_ff);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // quartile sub-ranges; a single sample serves as both quartiles
   assign half_n = cnt_ff >> 1;
   assign hq     = (half_n == '0) ? CW'(1) : half_n;

   always_comb begin
      case (k_ff)
         3'd0:    quart_addr = (cnt_ff - 1'b1) >> 1;
         3'd1:    quart_addr = cnt_ff >> 1;
         3'd2:    quart_addr = (hq - 1'b1) >> 1;
         3'd3:    quart_addr = hq >> 1;
         3'd4:    quart_addr = cnt_ff - hq + ((hq - 1'b1) >> 1);
         default: quart_addr = cnt_ff - hq + (hq >> 1);
      endcase
   end

   // ram port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = sample;
      rd_addr = i_ff[AW-1:0];
      case (state_ff)
         S_LOAD: begin
            wr_en = req_acc && has_room;
         end
         S_VALUE: begin
            rd_addr = AW'(i_ff - 1'b1);
         end
         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = shift_gt ? rd_data : v_ff;
            rd_addr = AW'(j_ff - CW'(2));
         end
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = v_ff;
         end
         S_QUART: begin
            rd_addr = quart_addr[AW-1:0];
         end
         S_SCAN: begin
            rd_addr = idx_ff[AW-1:0];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   iqr_ram #(
      .WIDTH (SB),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   iqr_divider #(
      .NUM_W (SUM_W),
      .DEN_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // result fields widened here, cut to their word widths when the result word is packed
   assign mean_wide = 128'(quotient);
   assign med_wide  = 64'(med_ff);
   assign q1_wide   = 64'(q1_ff);
   assign q3_wide   = 64'(q3_ff);
   assign outl_wide = 64'(outl_ff);
   assign cnt_wide  = 64'(cnt_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         // output register: load a finished result or drain an accepted one
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  if (has_room) begin
                     cnt_ff <= n_after;
                     sum_ff <= sum_ff + SUM_W'(sample);
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     i_ff <= CW'(1);
                     k_ff <= '0;
                     state_ff <= (n_after > CW'(1)) ? S_FETCH : S_QUART;
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_VALUE;
            end
            S_VALUE: begin
               v_ff     <= rd_data;
               j_ff     <= i_ff;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (shift_gt) begin
                  j_ff <= j_ff - 1'b1;
                  if (j_ff == CW'(1)) begin
                     state_ff <= S_PLACE;
                  end
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= (i_ff + 1'b1 == cnt_ff) ? S_QUART : S_FETCH;
               end
            end
            S_PLACE: begin
               i_ff     <= i_ff + 1'b1;
               state_ff <= (i_ff + 1'b1 == cnt_ff) ? S_QUART : S_FETCH;
            end
            S_QUART: begin
               // accumulate the pair read for each median
               case (k_ff)
                  3'd1:    med_ff <= HW'(rd_data);
                  3'd2:    med_ff <= med_ff + HW'(rd_data);
                  3'd3:    q1_ff  <= HW'(rd_data);
                  3'd4:    q1_ff  <= q1_ff + HW'(rd_data);
                  3'd5:    q3_ff  <= HW'(rd_data);
                  3'd6:    q3_ff  <= q3_ff + HW'(rd_data);
                  default: med_ff <= med_ff;
               endcase
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd6) begin
                  state_ff <= S_BOUND;
               end
            end
            S_BOUND: begin
               bound_ff <= (BW'(q3_ff) << 2) + BW'(q3_ff)
                           - ((BW'(q1_ff) << 1) + BW'(q1_ff));
               idx_ff   <= '0;
               pend_ff  <= 1'b0;
               outl_ff  <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (idx_ff < cnt_ff) begin
                  idx_ff  <= idx_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff && (BW'({rd_data, 2'b00}) > bound_ff)) begin
                  outl_ff <= outl_ff + 1'b1;
               end
               if (pend_ff && idx_ff == cnt_ff) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff  <= {7'd0,
                                   cnt_wide[OCOUNT_W-1:0],
                                   outl_wide[OCOUNT_W-1:0],
                                   q3_wide[HALF_W-1:0],
                                   q1_wide[HALF_W-1:0],
                                   med_wide[HALF_W-1:0],
                                   mean_wide[MEAN_W-1:0]};
                  rsp_user_ff  <= drop_ff;
                  cnt_ff       <= '0;
                  sum_ff       <= '0;
                  drop_ff      <= 1'b0;
                  state_ff     <= S_LOAD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   import iqr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SAMPLES = 1024;
   localparam int STALL_LIMIT = 4000000;

   typedef struct packed {
      logic [31:0] mean_value;
      logic [32:0] median_half;
      logic [32:0] lower_quartile_half;
      logic [32:0] upper_quartile_half;
      logic [10:0] outlier_count;
      logic [10:0] sample_count;
      logic        overflowed;
   } stats_t;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [31:0]      req_tdata;   // sample
   logic             req_tlast;   // last
   logic             rsp_tvalid;
   logic             rsp_tready;
   // mean_value, median_half, lower_quartile_half, upper_quartile_half,
   // outlier_count, sample_count, zero pad
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;   // overflowed

   iqr_outlier_statistics_core #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // predictor state
   logic [31:0] set_samples[$];
   logic [41:0] set_sum;
   logic        set_dropped;
   stats_t      expected_stats[$];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // median in half units of m sorted values from base
   function automatic logic [32:0] median_half_of(ref logic [31:0] v[$], input int base,
                                                  input int m);
      int mid;
      mid = base + m / 2;
      if (m % 2 == 1) begin
         return {v[mid], 1'b0};
      end
      return {1'b0, v[mid - 1]} + {1'b0, v[mid]};
   endfunction

   // update the set model with one word, queue a result when the set closes
   task automatic predict_stats(input logic [31:0] sample, input logic last);
      stats_t      r;
      logic [31:0] sorted[$];
      logic [36:0] bound;
      int          n;
      int          h;
      int          cnt;
      if (set_samples.size() < MAX_SAMPLES) begin
         set_samples.push_back(sample);
         set_sum = set_sum + sample;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         sorted = set_samples;
         sorted.sort();
         n = sorted.size();
         h = n / 2;
         r.median_half = median_half_of(sorted, 0, n);
         if (h == 0) begin
            r.lower_quartile_half = {sorted[0], 1'b0};
            r.upper_quartile_half = r.lower_quartile_half;
         end else begin
            r.lower_quartile_half = median_half_of(sorted, 0, h);
            r.upper_quartile_half = median_half_of(sorted, n - h, h);
         end
         // exact fence: 4*s > 5*q3h - 3*q1h, q3h >= q1h so no wrap
         bound = 37'(r.upper_quartile_half) * 5 - 37'(r.lower_quartile_half) * 3;
         cnt = 0;
         foreach (sorted[i]) begin
            if ({3'b0, sorted[i], 2'b0} > bound) begin
               cnt++;
            end
         end
         r.mean_value = 32'(set_sum / n);
         r.outlier_count = 11'(cnt);
         r.sample_count = 11'(n);
         r.overflowed = set_dropped;
         expected_stats.push_back(r);
         set_samples.delete();
         set_sum = '0;
         set_dropped = 1'b0;
      end
   endtask

   // send one word, predicting at acceptance
   task automatic send_sample(input logic [31:0] sample, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_stats(sample, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_stats.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // random value biased toward extremes and small spreads
   function automatic logic [31:0] pick_sample(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(1000);
         2: return 32'hFFFF_FFFF - $urandom_range(50);
         default: return 1000 + $urandom_range(20);
      endcase
   endfunction

   task automatic send_set(input int n, input int kind);
      for (int i = 0; i < n; i++) begin
         // occasional spike to create outliers
         if ($urandom_range(9) == 0) begin
            send_sample(pick_sample(0), i == n - 1);
         end else begin
            send_sample(pick_sample(kind), i == n - 1);
         end
      end
   endtask

   // directed sets: single sample, pairs, odd and even sizes, extremes
   task automatic test_directed();
      send_sample(32'd0, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'd3, 1'b0);
      send_sample(32'd8, 1'b1);
      send_sample(32'd10, 1'b0);
      send_sample(32'd10, 1'b0);
      send_sample(32'd10, 1'b0);
      send_sample(32'd10, 1'b0);
      send_sample(32'd500, 1'b1);
      send_sample(32'h5555_5555, 1'b0);
      send_sample(32'hAAAA_AAAA, 1'b0);
      send_sample(32'd1, 1'b0);
      send_sample(32'd9, 1'b0);
      send_sample(32'd7, 1'b1);
      wait_drained();
   endtask

   // full store, then dropped words including a dropped closing word
   task automatic test_overflow();
      for (int i = 0; i < MAX_SAMPLES + 3; i++) begin
         send_sample(pick_sample(i % 4), i == MAX_SAMPLES + 2);
      end
      wait_drained();
   endtask

   // random sets under one idling mode
   task automatic test_random(input int send_pct, input int recv_pct, input int words);
      int sent;
      int n;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < words) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
         send_set(n, $urandom_range(3));
         sent += n;
      end
      wait_drained();
   endtask

   // receiver ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      stats_t got;
      stats_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mean_value          = rsp_tdata[31:0];
         got.median_half         = rsp_tdata[64:32];
         got.lower_quartile_half = rsp_tdata[97:65];
         got.upper_quartile_half = rsp_tdata[130:98];
         got.outlier_count       = rsp_tdata[141:131];
         got.sample_count        = rsp_tdata[152:142];
         got.overflowed          = rsp_tuser;
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result word %h", got);
            end
         end else begin
            want = expected_stats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp mean %0d med %0d q1 %0d q3 %0d out %0d n %0d ovf %0d",
                           want.mean_value, want.median_half, want.lower_quartile_half,
                           want.upper_quartile_half, want.outlier_count,
                           want.sample_count, want.overflowed);
                  $display("         got mean %0d med %0d q1 %0d q3 %0d out %0d n %0d ovf %0d",
                           got.mean_value, got.median_half, got.lower_quartile_half,
                           got.upper_quartile_half, got.outlier_count,
                           got.sample_count, got.overflowed);
               end
            end
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      set_sum        = '0;
      set_dropped    = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random(0, 0, 220);
      test_random(65, 0, 220);
      test_random(0, 65, 220);
      test_random(16, 16, 220);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_stats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== iqr_outlier_statistics_core.f =====
design/iqr_pkg.sv
design/iqr_ram.sv
design/iqr_divider.sv
design/iqr_outlier_statistics_core.sv
tb/sv/tb_top.sv
